@@ rtl/core/pcb_pkg.sv @@
// Shared types and constants for the pretrigger capture buffer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pcb_pkg;

  // Buffer geometry. DEPTH must be a power of two so row counters wrap on their own.
  localparam int DEPTH         = 1024;
  localparam int CHANNELS      = 4;
  localparam int SAMPLE_FIELDS = 4;
  localparam int WORD_W        = 32;
  localparam int ROW_W         = $clog2(DEPTH);
  localparam int HELD_W        = $clog2(DEPTH + 1);
  localparam int CH_SEL_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Fixed port field widths.
  localparam int CMD_W       = 2;
  localparam int ROW_FIELD_W = 10;
  localparam int CH_FIELD_W  = 2;
  localparam int STATUS_W    = 2;
  localparam int CHANS_W     = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  // Quiet NaN stored for unconnected channels.
  localparam logic [WORD_W-1:0] NAN_WORD = 32'h7FC0_0000;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Acquisition phase codes.
  localparam logic [STATUS_W-1:0] PH_UNTRIG = 2'd0;
  localparam logic [STATUS_W-1:0] PH_TRIG   = 2'd1;
  localparam logic [STATUS_W-1:0] PH_DONE   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRETRIG  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS   = 2'd2;

  typedef logic [CHANNELS-1:0][WORD_W-1:0] row_t;

  typedef struct packed {
    logic [HELD_W-1:0]  pretrig;
    logic [CHANS_W-1:0] chans;
    logic               bypass;
  } cfg_t;

  typedef struct packed {
    logic                wr_en;
    logic [ROW_W-1:0]    wr_row;
    logic [STATUS_W-1:0] phase;
    logic [HELD_W-1:0]   held;
    logic [ROW_W-1:0]    trig_row;
    logic [ROW_W-1:0]    last_row;
  } ctrl_t;

endpackage

@@ rtl/core/pcb_store.sv @@
// Row memory of the capture buffer: one full row written, one row read per cycle.
// Depends on pcb_pkg.
`timescale 1ns / 1ps

module pcb_store
  import pcb_pkg::*;
(
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [ROW_W-1:0] wr_row_i,
  input  row_t             wr_data_i,
  input  logic             rd_en_i,
  input  logic [ROW_W-1:0] rd_row_i,
  output row_t             rd_data_o
);

  row_t mem [DEPTH];
  row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_row_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/core/pcb_ctrl.sv @@
// Acquisition sequencer: phase, held count, write pointer, trigger and last rows.
// Depends on pcb_pkg.
`timescale 1ns / 1ps

module pcb_ctrl
  import pcb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic             trigger_i,
  input  cfg_t             cfg_i,
  output ctrl_t            ctrl_o
);

  logic [STATUS_W-1:0] phase_q, phase_d;
  logic [HELD_W-1:0]   held_q, held_d;
  logic [ROW_W-1:0]    wrow_q, wrow_d;
  logic [ROW_W-1:0]    trow_q, trow_d;
  logic [ROW_W-1:0]    frow_q, frow_d;
  logic                wr_en;
  logic                trig;

  assign trig = trigger_i | cfg_i.bypass;

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    wrow_d  = wrow_q;
    trow_d  = trow_q;
    frow_d  = frow_q;
    wr_en   = 1'b0;
    if (accept_i) begin
      case (cmd_i)
        CMD_TICK: begin
          if (phase_d == PH_UNTRIG && trig) begin
            phase_d = PH_TRIG;
            if (held_d > cfg_i.pretrig) begin
              held_d = cfg_i.pretrig;
            end
            trow_d = wrow_q;
          end
          // buffer already full: stop without recording this tick
          if (phase_d == PH_TRIG && held_d >= HELD_W'(DEPTH)) begin
            phase_d = PH_DONE;
            frow_d  = wrow_q - ROW_W'(1);
          end
          if (phase_d != PH_DONE) begin
            wr_en  = 1'b1;
            wrow_d = wrow_q + ROW_W'(1);
            if (held_d < HELD_W'(DEPTH)) begin
              held_d = held_d + HELD_W'(1);
            end
          end
        end
        CMD_START: begin
          phase_d = PH_UNTRIG;
          held_d  = '0;
          wrow_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_UNTRIG;
      held_q  <= '0;
      wrow_q  <= '0;
      trow_q  <= '0;
      frow_q  <= ROW_W'(DEPTH - 1);
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      wrow_q  <= wrow_d;
      trow_q  <= trow_d;
      frow_q  <= frow_d;
    end
  end

  assign ctrl_o.wr_en    = wr_en;
  assign ctrl_o.wr_row   = wrow_q;
  assign ctrl_o.phase    = phase_q;
  assign ctrl_o.held     = held_q;
  assign ctrl_o.trig_row = trow_q;
  assign ctrl_o.last_row = frow_q;

endmodule

@@ rtl/core/pretrigger_capture_buffer.sv @@
// Top level of the pretrigger capture buffer: config registers, row assembly,
// result register and read-word select. Depends on pcb_pkg, pcb_ctrl, pcb_store.
`timescale 1ns / 1ps

// Logic-analyzer style capture engine. Each accepted word is a command: a sample
// tick records one row of CHANNELS 32-bit words into a 1024-row ring (channels at
// or beyond channels_connected hold the quiet NaN 0x7FC00000), a start rearms the
// engine, and a read returns one stored word. Throughput is one word per clock while
// results are taken: the sequencer updates and the row write both happen at the
// accept edge, and the read is served by the row memory's single registered read
// port at that same edge, so the result is ready the cycle after acceptance. The
// result register decouples the two sides: a new word is accepted while a result
// is taken in the same cycle. acq_status, trigger_row and last_row show the state
// after the word. No clearing pass after reset: reading a row never written gives
// an undefined word. Configuration writes take effect at the next edge whatever is
// in flight, so issue them only while no word is pending.
module pretrigger_capture_buffer
  import pcb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // input words
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [CMD_W-1:0]       cmd_i,
  input  logic                   trigger_i,
  input  logic [WORD_W-1:0]      sample_ch0_i,
  input  logic [WORD_W-1:0]      sample_ch1_i,
  input  logic [WORD_W-1:0]      sample_ch2_i,
  input  logic [WORD_W-1:0]      sample_ch3_i,
  input  logic [ROW_FIELD_W-1:0] read_row_i,
  input  logic [CH_FIELD_W-1:0]  read_channel_i,
  // result words
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [STATUS_W-1:0]    acq_status_o,
  output logic [ROW_FIELD_W-1:0] trigger_row_o,
  output logic [ROW_FIELD_W-1:0] last_row_o,
  output logic [WORD_W-1:0]      read_word_o
);

  // ---------------- configuration registers ----------------
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PRETRIG: begin
          // saturate at buffer depth
          if (HELD_W'(cfg_wdata_i) > HELD_W'(DEPTH)) begin
            cfg_d.pretrig = HELD_W'(DEPTH);
          end else begin
            cfg_d.pretrig = HELD_W'(cfg_wdata_i);
          end
        end
        CFG_CHANNELS: cfg_d.chans  = cfg_wdata_i[CHANS_W-1:0];
        CFG_BYPASS:   cfg_d.bypass = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pretrig <= '0;
      cfg_q.chans   <= '0;
      cfg_q.bypass  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // ---------------- handshake ----------------
  logic out_valid_q;
  logic in_accept;

  // result register frees up when empty or being drained this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------- sequencer ----------------
  ctrl_t ctrl;

  pcb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .cmd_i     (cmd_i),
    .trigger_i (trigger_i),
    .cfg_i     (cfg_q),
    .ctrl_o    (ctrl)
  );

  // ---------------- row assembly ----------------
  logic [SAMPLE_FIELDS-1:0][WORD_W-1:0] samples;
  row_t                                 wr_data;

  assign samples = {sample_ch3_i, sample_ch2_i, sample_ch1_i, sample_ch0_i};

  // channels past the connected count (or past the four sample fields) get NaN
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (ch < SAMPLE_FIELDS && ch < int'(cfg_q.chans)) begin
        wr_data[ch] = samples[ch % SAMPLE_FIELDS];
      end else begin
        wr_data[ch] = NAN_WORD;
      end
    end
  end

  // ---------------- row memory ----------------
  logic rd_en;
  row_t rd_data;

  assign rd_en = in_accept && (cmd_i == CMD_READ);

  // DEPTH is a power of two, so the row modulo is a truncation
  pcb_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ctrl.wr_en),
    .wr_row_i  (ctrl.wr_row),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_row_i  (ROW_W'(read_row_i)),
    .rd_data_o (rd_data)
  );

  // ---------------- read-word select ----------------
  logic                  rd_hit_q;
  logic [CH_SEL_W-1:0]   rd_ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_hit_q <= 1'b0;
    end else if (in_accept) begin
      rd_hit_q <= (cmd_i == CMD_READ) && (int'(read_channel_i) < CHANNELS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_ch_q <= CH_SEL_W'(read_channel_i);
    end
  end

  assign read_word_o = rd_hit_q ? rd_data[rd_ch_q] : '0;

  // state only moves on acceptance, so it doubles as the result register
  assign acq_status_o  = ctrl.phase;
  assign trigger_row_o = ROW_FIELD_W'(ctrl.trig_row);
  assign last_row_o    = ROW_FIELD_W'(ctrl.last_row);

  // ---------------- assertions ----------------
  a_wr_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.wr_en |-> (in_accept && cmd_i == CMD_TICK))
    else $error("row write without an accepted sample tick");

  a_held_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.held <= HELD_W'(DEPTH))
    else $error("held count above buffer depth");

  a_start_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && cmd_i == CMD_START) |=> (acq_status_o == PH_UNTRIG && ctrl.held == '0))
    else $error("start did not rearm the engine");

  a_done_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.phase == PH_DONE) |-> !ctrl.wr_en)
    else $error("row written after capture finished");

endmodule
